// ===== sv/sbrp_pkg.sv =====
// ----------------------------------------------------------------------------
// sbrp_pkg
// Shared constants and types for the STUN binding response parser.
// ----------------------------------------------------------------------------
package sbrp_pkg;

  localparam logic [15:0] MSG_SUCCESS  = 16'h0101;
  localparam logic [31:0] COOKIE       = 32'h2112A442;
  localparam logic [15:0] KIND_MAPPED  = 16'h0001;
  localparam logic [15:0] KIND_XOR     = 16'h0020;
  localparam logic [7:0]  FAMILY_V4    = 8'h01;
  localparam int          HDR_LEN      = 20;
  localparam logic [15:0] MIN_ADDR_LEN = 16'd8;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_TXID_HIGH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TXID_LOW  = 2'd1;

  localparam int STATUS_W = 3;
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_SHORT     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_HDR_BAD   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_OVERRUN   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NO_ADDR   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_TOO_LONG  = 3'd5;

  // output tdata: status[2:0], mapped_ip[34:3], mapped_port[50:35], from_xor[51]
  localparam int OUT_DATA_W = 56;

  typedef struct packed {
    logic                found;
    logic [STATUS_W-1:0] status;
    logic [31:0]         mapped_ip;
    logic [15:0]         mapped_port;
    logic                from_xor;
  } sbrp_result_t;

endpackage

// ===== sv/sbrp_parse_core.sv =====
// ----------------------------------------------------------------------------
// sbrp_parse_core
// Per-packet parse state: header check, attribute walk, address capture and
// final status, updated once per transferred byte.
// ----------------------------------------------------------------------------
module sbrp_parse_core
  import sbrp_pkg::*;
#(
  parameter int MAX_BYTES = 512
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         step,
  input  logic [7:0]   data_byte,
  input  logic         last_byte,
  input  logic [31:0]  txid_high,
  input  logic [63:0]  txid_low,
  output sbrp_result_t result
);

  localparam int CNT_W = $clog2(MAX_BYTES + 2);
  localparam int END_W = ((CNT_W > 17) ? CNT_W : 17) + 1;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BYTES);
  localparam logic [CNT_W-1:0] CNT_HDR = CNT_W'(HDR_LEN);

  logic [CNT_W-1:0] byte_count_r, byte_count_nxt;
  logic             header_ok_r, header_ok_nxt;
  logic [CNT_W-1:0] attr_start_r, attr_start_nxt;
  logic [15:0]      attr_kind_r, attr_kind_nxt;
  logic [15:0]      attr_length_r, attr_length_nxt;
  logic             cand_valid_r, cand_valid_nxt;
  logic [47:0]      cand_addr_r, cand_addr_nxt;
  logic             match_done_r, match_done_nxt;
  logic [48:0]      match_addr_r, match_addr_nxt;

  logic [159:0]     hdr_exp;
  logic [4:0]       hdr_idx;
  logic [7:0]       hdr_byte;
  logic             hdr_any;
  logic [CNT_W-1:0] rel;
  logic             attr_act;
  logic [16:0]      padded;
  logic [END_W-1:0] end_pos;
  logic [END_W-1:0] p_plus1;
  logic             xor_form;
  logic [47:0]      addr_out;
  logic [CNT_W:0]   ovr_lim;

  assign hdr_exp  = {MSG_SUCCESS, 16'h0000, COOKIE, txid_high, txid_low};
  assign hdr_idx  = 5'(HDR_LEN - 1) - byte_count_r[4:0];
  assign hdr_byte = hdr_exp[hdr_idx*8 +: 8];
  assign hdr_any  = (byte_count_r[4:0] == 5'd2) || (byte_count_r[4:0] == 5'd3);
  assign rel      = byte_count_r - attr_start_r;
  assign attr_act = (byte_count_r < CNT_MAX) && (byte_count_r >= CNT_HDR) &&
                    !match_done_r && (byte_count_r >= attr_start_r);
  assign padded   = ({1'b0, attr_length_nxt} + 17'd3) & ~17'd3;
  assign end_pos  = END_W'(attr_start_r) + END_W'(4) + END_W'(padded);
  assign p_plus1  = END_W'(byte_count_r) + END_W'(1);
  assign xor_form = (attr_kind_nxt == KIND_XOR);
  assign addr_out = xor_form ? (cand_addr_nxt ^ {COOKIE[31:16], COOKIE}) : cand_addr_nxt;

  always_comb begin
    byte_count_nxt  = byte_count_r;
    header_ok_nxt   = header_ok_r;
    attr_start_nxt  = attr_start_r;
    attr_kind_nxt   = attr_kind_r;
    attr_length_nxt = attr_length_r;
    cand_valid_nxt  = cand_valid_r;
    cand_addr_nxt   = cand_addr_r;
    match_done_nxt  = match_done_r;
    match_addr_nxt  = match_addr_r;

    if (byte_count_r < CNT_HDR) begin
      if (!hdr_any && (hdr_byte != data_byte)) begin
        header_ok_nxt = 1'b0;
      end
    end

    if (attr_act) begin
      if (rel == CNT_W'(0)) begin
        attr_kind_nxt = {data_byte, 8'h00};
      end else if (rel == CNT_W'(1)) begin
        attr_kind_nxt = {attr_kind_r[15:8], data_byte};
      end else if (rel == CNT_W'(2)) begin
        attr_length_nxt = {data_byte, 8'h00};
      end else if (rel == CNT_W'(3)) begin
        attr_length_nxt = {attr_length_r[15:8], data_byte};
        cand_valid_nxt  = ((attr_kind_r == KIND_XOR) || (attr_kind_r == KIND_MAPPED)) &&
                          ({attr_length_r[15:8], data_byte} >= MIN_ADDR_LEN);
        cand_addr_nxt   = '0;
      end else if (rel == CNT_W'(5)) begin
        if (data_byte != FAMILY_V4) begin
          cand_valid_nxt = 1'b0;
        end
      end else if ((rel >= CNT_W'(6)) && (rel <= CNT_W'(11))) begin
        cand_addr_nxt = {cand_addr_r[39:0], data_byte};
      end

      if ((rel >= CNT_W'(3)) && (p_plus1 == end_pos)) begin
        if (cand_valid_nxt) begin
          match_addr_nxt = {xor_form, addr_out};
          match_done_nxt = 1'b1;
        end else begin
          attr_start_nxt = byte_count_r + CNT_W'(1);
          cand_valid_nxt = 1'b0;
          cand_addr_nxt  = '0;
        end
      end
    end

    if (byte_count_r <= CNT_MAX) begin
      byte_count_nxt = byte_count_r + CNT_W'(1);
    end
  end

  assign ovr_lim = {1'b0, attr_start_nxt} + (CNT_W+1)'(4);

  always_comb begin
    result = '0;
    if (byte_count_nxt > CNT_MAX) begin
      result.status = ST_TOO_LONG;
    end else if (byte_count_nxt < CNT_HDR) begin
      result.status = ST_SHORT;
    end else if (!header_ok_nxt) begin
      result.status = ST_HDR_BAD;
    end else if (match_done_nxt) begin
      result.status      = ST_OK;
      result.found       = 1'b1;
      result.mapped_ip   = match_addr_nxt[31:0];
      result.mapped_port = match_addr_nxt[47:32];
      result.from_xor    = match_addr_nxt[48];
    end else if (ovr_lim <= {1'b0, byte_count_nxt}) begin
      result.status = ST_OVERRUN;
    end else begin
      result.status = ST_NO_ADDR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && last_byte)) begin
      byte_count_r  <= '0;
      header_ok_r   <= 1'b1;
      attr_start_r  <= CNT_HDR;
      attr_kind_r   <= '0;
      attr_length_r <= '0;
      cand_valid_r  <= 1'b0;
      cand_addr_r   <= '0;
      match_done_r  <= 1'b0;
      match_addr_r  <= '0;
    end else if (step) begin
      byte_count_r  <= byte_count_nxt;
      header_ok_r   <= header_ok_nxt;
      attr_start_r  <= attr_start_nxt;
      attr_kind_r   <= attr_kind_nxt;
      attr_length_r <= attr_length_nxt;
      cand_valid_r  <= cand_valid_nxt;
      cand_addr_r   <= cand_addr_nxt;
      match_done_r  <= match_done_nxt;
      match_addr_r  <= match_addr_nxt;
    end
  end

endmodule

// ===== sv/stun_binding_response_parser.sv =====
// ----------------------------------------------------------------------------
// stun_binding_response_parser
// Byte-stream STUN binding response parser returning the mapped IPv4 address.
// ----------------------------------------------------------------------------
//  channel | direction | tdata                           | tuser | tlast
//  in_     | slave     | data_byte                       | -     | last_byte
//  out_    | master    | status, ip, port, from_xor      | found | -
//  cfg_    | write     | wdata = txid_high / txid_low    | -     | -
//
// One byte per cycle sustained unless a last byte waits on a stalled output.
// A transferred byte waits in the input register and is parsed from there;
// the result of a last byte is registered in the output register as that
// byte is parsed. Reset is synchronous and clears the packet state. A stalled
// output holds only a last byte back; other bytes flow into the parse state.
// ----------------------------------------------------------------------------
module stun_binding_response_parser
  import sbrp_pkg::*;
#(
  parameter int MAX_BYTES = 512
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // data_byte[7:0]
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // status[2:0], mapped_ip[34:3],
                                            // mapped_port[50:35], from_xor[51]
  output logic                  out_tuser,  // found
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [63:0]           cfg_wdata
);

  logic [31:0]  txid_high_r;
  logic [63:0]  txid_low_r;
  logic         in_valid_r;
  logic [7:0]   in_byte_r;
  logic         in_last_r;
  logic         step;
  logic         out_valid_r;
  sbrp_result_t out_res_r;
  sbrp_result_t core_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      txid_high_r <= '0;
      txid_low_r  <= '0;
    end else if (cfg_wr_en) begin
      if (cfg_addr == REG_TXID_HIGH) begin
        txid_high_r <= cfg_wdata[31:0];
      end else if (cfg_addr == REG_TXID_LOW) begin
        txid_low_r <= cfg_wdata;
      end
    end
  end

  assign step      = in_valid_r && (!in_last_r || !out_valid_r || out_tready);
  assign in_tready = !in_valid_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  sbrp_parse_core #(
    .MAX_BYTES(MAX_BYTES)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .data_byte (in_byte_r),
    .last_byte (in_last_r),
    .txid_high (txid_high_r),
    .txid_low  (txid_low_r),
    .result    (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step && in_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && in_last_r) begin
      out_res_r <= core_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.found;
  assign out_tdata  = {4'b0000, out_res_r.from_xor, out_res_r.mapped_port,
                       out_res_r.mapped_ip, out_res_r.status};

endmodule

// ===== sv/sbrp_checker.sv =====
// ----------------------------------------------------------------------------
// sbrp_checker
// Port-level checks for the STUN binding response parser.
// ----------------------------------------------------------------------------
module sbrp_checker
  import sbrp_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tuser
);

  logic [STATUS_W-1:0] st;
  assign st = out_tdata[2:0];

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == (st == ST_OK)))
    else $error("found flag disagrees with status");

  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> (out_tdata[OUT_DATA_W-1:3] == '0))
    else $error("address fields set without a match");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (st == ST_OK || st == ST_SHORT || st == ST_HDR_BAD ||
                    st == ST_OVERRUN || st == ST_NO_ADDR || st == ST_TOO_LONG))
    else $error("status code out of range");

endmodule

bind stun_binding_response_parser sbrp_checker u_sbrp_checker (.*);
